// ===== design/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg
// Shared constants and types for the polygon scanline span fill block.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int XW               = 24;
   localparam int RW               = 16;
   localparam int MW               = 16;
   localparam int MAX_VERTICES_DEF = 32;
   localparam int FRAC_BITS_DEF    = 8;
   localparam int MAX_RESULTS      = 16;
   localparam int QDEPTH           = 4;
   localparam int CSR_DW           = 32;
   localparam int CSR_AW           = 3;

   localparam logic [MW-1:0] MAP_WIDTH_RST  = 16'd1024;
   localparam logic [MW-1:0] MAP_HEIGHT_RST = 16'd1024;

   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== design/psf_ram.sv =====
// ----------------------------------------------------------------------------
// psf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psf_ram #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [W-1:0]             wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [W-1:0]             rdata
);

   logic [W-1:0] mem_ff [DEPTH];
   logic [W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/psf_front.sv =====
// ----------------------------------------------------------------------------
// psf_front
// Request intake: stores vertices, walks the edges of a queried row and
// computes each crossing ceiling with a shift-subtract divider.
// ----------------------------------------------------------------------------
module psf_front #(
   parameter int MAX_VERTICES = psf_pkg::MAX_VERTICES_DEF,
   parameter int FRAC_BITS    = psf_pkg::FRAC_BITS_DEF,
   parameter int CXW          = psf_pkg::XW - FRAC_BITS + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       req_action,
   input  logic [psf_pkg::XW-1:0]     req_vertex_x,
   input  logic [psf_pkg::XW-1:0]     req_vertex_y,
   input  logic                       req_last_vertex,
   input  logic [psf_pkg::RW-1:0]     req_row,
   input  logic [psf_pkg::MW-1:0]     map_height,
   input  psf_pkg::q_status_type      q_status,
   output logic                       push,
   output logic                       push_end,
   output logic signed [CXW-1:0]      push_value,
   output logic                       busy
);

   localparam int XW   = psf_pkg::XW;
   localparam int VCW  = $clog2(MAX_VERTICES + 2);
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int IW   = (XW + 2 > psf_pkg::RW + FRAC_BITS + 2) ?
                         XW + 2 : psf_pkg::RW + FRAC_BITS + 2;
   localparam int DXW  = IW + 1;
   localparam int PW   = 2 * DXW;
   localparam int TW   = PW + 1;
   localparam int QW   = XW - FRAC_BITS;
   localparam int SCW  = $clog2(QW + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_PUSH = 3'd6;
   localparam logic [2:0] S_END  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [VCW-1:0]        vcount_ff, vcount_in;
   logic                  complete_ff, complete_in;
   logic [VCW-1:0]        idx_ff, idx_in;
   logic                  lastedge_ff, lastedge_in;
   logic signed [IW-1:0]  yrow_ff, yrow_in;
   logic signed [IW-1:0]  prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic signed [IW-1:0]  xl_ff, xl_in, yl_ff, yl_in;
   logic signed [DXW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PW-1:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic                  neg_ff, neg_in;
   logic [TW-1:0]         rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QW-1:0]         q_ff, q_in;
   logic [SCW-1:0]        step_ff, step_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [2*XW-1:0]       ram_rdata;
   logic [VCW-1:0]        base;
   logic signed [IW-1:0]  cx, cy, hx, hy;
   logic signed [DXW-1:0] ydiff;
   logic signed [TW-1:0]  tsum;

   psf_ram #(.W(2 * XW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req_vertex_x, req_vertex_y}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      base = complete_ff ? '0 : vcount_ff;
      ram_we = accept && (req_action == psf_pkg::ACT_LOAD) && (base < VCW'(MAX_VERTICES));
      ram_waddr = base[AW-1:0];
      ram_raddr = (idx_ff == vcount_ff) ? '0 : idx_ff[AW-1:0];
      hx = $signed({{(IW-XW){ram_rdata[2*XW-1]}}, ram_rdata[2*XW-1:XW]});
      hy = $signed({{(IW-XW){ram_rdata[XW-1]}}, ram_rdata[XW-1:0]});
      cx = (hx <<< 1) - (IW'(1) <<< FRAC_BITS);
      cy = (hy <<< 1) - (IW'(1) <<< FRAC_BITS);
      ydiff = $signed({yrow_ff[IW-1], yrow_ff}) - $signed({yl_ff[IW-1], yl_ff});
      tsum = $signed({p1_ff[PW-1], p1_ff}) + $signed({p2_ff[PW-1], p2_ff});
   end

   always_comb begin
      state_in    = state_ff;
      vcount_in   = vcount_ff;
      complete_in = complete_ff;
      idx_in      = idx_ff;
      lastedge_in = lastedge_ff;
      yrow_in     = yrow_ff;
      prevx_in    = prevx_ff;
      prevy_in    = prevy_ff;
      xl_in       = xl_ff;
      yl_in       = yl_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      dsh_in      = dsh_ff;
      q_in        = q_ff;
      step_in     = step_ff;
      push        = 1'b0;
      push_end    = 1'b0;
      push_value  = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_action == psf_pkg::ACT_LOAD) begin
               vcount_in   = ram_we ? base + VCW'(1) : base;
               complete_in = req_last_vertex;
            end else if (accept) begin
               idx_in  = '0;
               yrow_in = $signed(IW'({req_row, {(FRAC_BITS + 1){1'b0}}}));
               if (complete_ff && vcount_ff >= VCW'(3) && req_row < map_height) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_END;
               end
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            idx_in   = idx_ff + VCW'(1);
            prevx_in = cx;
            prevy_in = cy;
            if (idx_ff == '0) begin
               state_in = S_READ;
            end else begin
               lastedge_in = (idx_ff == vcount_ff);
               if (prevy_ff < cy) begin
                  xl_in = prevx_ff;
                  yl_in = prevy_ff;
                  dx_in = $signed({cx[IW-1], cx}) - $signed({prevx_ff[IW-1], prevx_ff});
                  dy_in = $signed({cy[IW-1], cy}) - $signed({prevy_ff[IW-1], prevy_ff});
               end else begin
                  xl_in = cx;
                  yl_in = cy;
                  dx_in = $signed({prevx_ff[IW-1], prevx_ff}) - $signed({cx[IW-1], cx});
                  dy_in = $signed({prevy_ff[IW-1], prevy_ff}) - $signed({cy[IW-1], cy});
               end
               if (prevy_ff != cy &&
                   yrow_ff > ((prevy_ff < cy) ? prevy_ff : cy) &&
                   yrow_ff <= ((prevy_ff < cy) ? cy : prevy_ff)) begin
                  state_in = S_MUL;
               end else if (idx_ff == vcount_ff) begin
                  state_in = S_END;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_MUL: begin
            p1_in    = PW'($signed({xl_ff[IW-1], xl_ff}) * dy_ff);
            p2_in    = PW'(ydiff * dx_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            neg_in   = tsum[TW-1];
            rem_in   = tsum[TW-1] ? $unsigned(-tsum) : $unsigned(tsum);
            dsh_in   = TW'($unsigned(dy_ff)) << (FRAC_BITS + QW);
            q_in     = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + SCW'(1);
            if (step_ff == SCW'(QW - 1)) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            push_value = neg_ff ? -$signed({2'b00, q_ff}) :
                         $signed({2'b00, q_ff}) + $signed(CXW'(rem_ff != '0));
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = lastedge_ff ? S_END : S_READ;
            end
         end
         S_END: begin
            if (!q_status.full) begin
               push     = 1'b1;
               push_end = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         vcount_ff   <= '0;
         complete_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         vcount_ff   <= vcount_in;
         complete_ff <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lastedge_ff <= lastedge_in;
      yrow_ff     <= yrow_in;
      prevx_ff    <= prevx_in;
      prevy_ff    <= prevy_in;
      xl_ff       <= xl_in;
      yl_ff       <= yl_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/psf_queue.sv =====
// ----------------------------------------------------------------------------
// psf_queue
// Short FIFO carrying crossings and end marks from front to back.
// ----------------------------------------------------------------------------
module psf_queue #(
   parameter int W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [W-1:0]          push_data,
   input  logic                  pop,
   output logic [W-1:0]          head_data,
   output psf_pkg::q_status_type status
);

   localparam int D   = psf_pkg::QDEPTH;
   localparam int PTW = $clog2(D);

   logic [W-1:0]   data_ff [D];
   logic [PTW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTW:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + PTW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + PTW'(1) : rd_ff;
      cnt_in = cnt_ff + (PTW+1)'(push) - (PTW+1)'(pop);
      status.full  = (cnt_ff == (PTW+1)'(D));
      status.empty = (cnt_ff == '0);
      head_data    = data_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== design/psf_back.sv =====
// ----------------------------------------------------------------------------
// psf_back
// Sorts crossings into an insertion row, then pairs them into clipped spans.
// ----------------------------------------------------------------------------
module psf_back #(
   parameter int MAX_VERTICES = psf_pkg::MAX_VERTICES_DEF,
   parameter int CXW          = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psf_pkg::q_status_type   q_status,
   input  logic                    head_end,
   input  logic signed [CXW-1:0]   head_value,
   input  logic [psf_pkg::MW-1:0]  map_width,
   output logic                    pop,
   output logic                    busy,
   output logic                    rsp_valid,
   output logic [psf_pkg::MW-1:0]  rsp_span_start,
   output logic [psf_pkg::MW-1:0]  rsp_span_end,
   output logic                    rsp_span_valid,
   output logic                    rsp_last
);

   localparam int MW  = psf_pkg::MW;
   localparam int NCW = $clog2(MAX_VERTICES + 1);
   localparam int FCW = $clog2(psf_pkg::MAX_RESULTS);
   localparam int EW  = ((CXW > MW + 1) ? CXW : MW + 1) + 1;

   localparam logic [1:0] B_COLLECT = 2'd0;
   localparam logic [1:0] B_EMIT    = 2'd1;
   localparam logic [1:0] B_FINAL   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic signed [CXW-1:0] buf_ff [MAX_VERTICES];
   logic signed [CXW-1:0] buf_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] le;
   logic [NCW-1:0]        nc_ff, nc_in, pairs_ff, pairs_in;
   logic [FCW-1:0]        found_ff, found_in;
   logic                  pend_ff, pend_in;
   logic [MW-1:0]         pstart_ff, pstart_in, pend_end_ff, pend_end_in;
   logic                  ovalid_ff, ovalid_in, ospan_ff, ospan_in, olast_ff, olast_in;
   logic [MW-1:0]         ostart_ff, ostart_in, oend_ff, oend_in;
   logic signed [EW-1:0]  a_e, b_e, wmax, s_e, e_e;
   logic                  span_ok;

   always_comb begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
         le[k] = (NCW'(k) < nc_ff) && (buf_ff[k] <= head_value);
      end
      a_e  = EW'(buf_ff[0]);
      b_e  = EW'(buf_ff[1]) - EW'(1);
      wmax = $signed({{(EW-MW){1'b0}}, map_width}) - EW'(1);
      s_e  = (a_e < 0) ? '0 : a_e;
      e_e  = (b_e > wmax) ? wmax : b_e;
      span_ok = !(b_e < 0) && !(a_e > wmax) && !(s_e > e_e);
   end

   always_comb begin
      state_in    = state_ff;
      nc_in       = nc_ff;
      pairs_in    = pairs_ff;
      found_in    = found_ff;
      pend_in     = pend_ff;
      pstart_in   = pstart_ff;
      pend_end_in = pend_end_ff;
      ovalid_in   = 1'b0;
      ospan_in    = ospan_ff;
      olast_in    = olast_ff;
      ostart_in   = ostart_ff;
      oend_in     = oend_ff;
      pop         = 1'b0;
      for (int k = 0; k < MAX_VERTICES; k++) begin
         buf_in[k] = buf_ff[k];
      end
      case (state_ff)
         B_COLLECT: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (head_end) begin
                  pairs_in = nc_ff >> 1;
                  found_in = '0;
                  pend_in  = 1'b0;
                  state_in = B_EMIT;
               end else begin
                  nc_in = nc_ff + NCW'(1);
                  if (!le[0]) begin
                     buf_in[0] = head_value;
                  end
                  for (int k = 1; k < MAX_VERTICES; k++) begin
                     if (!le[k]) begin
                        buf_in[k] = le[k-1] ? head_value : buf_ff[k-1];
                     end
                  end
               end
            end
         end
         B_EMIT: begin
            if (pairs_ff == '0) begin
               state_in = B_FINAL;
            end else begin
               pairs_in = pairs_ff - NCW'(1);
               for (int k = 0; k < MAX_VERTICES - 2; k++) begin
                  buf_in[k] = buf_ff[k+2];
               end
               if (span_ok) begin
                  if (pend_ff) begin
                     ovalid_in = 1'b1;
                     ospan_in  = 1'b1;
                     olast_in  = 1'b0;
                     ostart_in = pstart_ff;
                     oend_in   = pend_end_ff;
                  end
                  pend_in     = 1'b1;
                  pstart_in   = s_e[MW-1:0];
                  pend_end_in = e_e[MW-1:0];
                  found_in    = found_ff + FCW'(1);
                  if (found_ff == FCW'(psf_pkg::MAX_RESULTS - 1)) begin
                     state_in = B_FINAL;
                  end
               end
            end
         end
         B_FINAL: begin
            ovalid_in = 1'b1;
            ospan_in  = pend_ff;
            olast_in  = 1'b1;
            ostart_in = pend_ff ? pstart_ff : '0;
            oend_in   = pend_ff ? pend_end_ff : '0;
            nc_in     = '0;
            pend_in   = 1'b0;
            state_in  = B_COLLECT;
         end
         default: begin
            state_in = B_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_COLLECT;
         nc_ff     <= '0;
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         nc_ff     <= nc_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
         buf_ff[k] <= buf_in[k];
      end
      pairs_ff    <= pairs_in;
      found_ff    <= found_in;
      pstart_ff   <= pstart_in;
      pend_end_ff <= pend_end_in;
      ospan_ff    <= ospan_in;
      olast_ff    <= olast_in;
      ostart_ff   <= ostart_in;
      oend_ff     <= oend_in;
   end

   assign busy           = (state_ff != B_COLLECT);
   assign rsp_valid      = ovalid_ff;
   assign rsp_span_start = ostart_ff;
   assign rsp_span_end   = oend_ff;
   assign rsp_span_valid = ospan_ff;
   assign rsp_last       = olast_ff;

endmodule

// ===== design/polygon_scanline_span_fill.sv =====
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill
// Even-odd scanline span fill of one stored polygon.
//
//   channel   ports            handshake
//   request   start, req_*     taken when start is high and busy is low
//   result    rsp_*            one cycle per result, marked by rsp_valid
//   csr       psel .. pready   APB write, map_width at 0, map_height at 4
//
// A vertex load is written straight into the vertex RAM. A row query walks all n
// edges: the first vertex and each edge cost a RAM read and a load step, and a
// crossing edge adds a multiply, an add, XW-FRAC_BITS divider steps (16 at
// defaults) and a push, which waits while the queue is full. The back end
// then takes the crossing pairs one by one and closes with a final result.
// The divider sets the query time. Reset is synchronous and clears control
// state only. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module polygon_scanline_span_fill #(
   parameter int MAX_VERTICES = psf_pkg::MAX_VERTICES_DEF,
   parameter int FRAC_BITS    = psf_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [psf_pkg::XW-1:0]        req_vertex_x,
   input  logic [psf_pkg::XW-1:0]        req_vertex_y,
   input  logic                          req_last_vertex,
   input  logic [psf_pkg::RW-1:0]        req_row,
   output logic                          rsp_valid,
   output logic [psf_pkg::MW-1:0]        rsp_span_start,
   output logic [psf_pkg::MW-1:0]        rsp_span_end,
   output logic                          rsp_span_valid,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [psf_pkg::CSR_AW-1:0]    paddr,
   input  logic [psf_pkg::CSR_DW-1:0]    pwdata,
   output logic [psf_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam int MW  = psf_pkg::MW;
   localparam int CXW = psf_pkg::XW - FRAC_BITS + 2;

   logic [MW-1:0]          map_width_ff, map_width_in, map_height_ff, map_height_in;
   logic                   csr_wr;
   logic                   accept;
   logic                   front_busy, back_busy;
   logic                   push, push_end, pop;
   logic signed [CXW-1:0]  push_value;
   logic [CXW:0]           head_data;
   psf_pkg::q_status_type  q_status;

   always_comb begin
      csr_wr        = psel && penable && pwrite;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_wr && paddr[2] == psf_pkg::REG_MAP_WIDTH) begin
         map_width_in = pwdata[MW-1:0];
      end
      if (csr_wr && paddr[2] == psf_pkg::REG_MAP_HEIGHT) begin
         map_height_in = pwdata[MW-1:0];
      end
      prdata = {{(psf_pkg::CSR_DW-MW){1'b0}},
                (paddr[2] == psf_pkg::REG_MAP_HEIGHT) ? map_height_ff : map_width_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= psf_pkg::MAP_WIDTH_RST;
         map_height_ff <= psf_pkg::MAP_HEIGHT_RST;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   assign pready = 1'b1;
   assign busy   = front_busy || !q_status.empty || back_busy;
   assign accept = start && !busy;

   psf_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .FRAC_BITS    (FRAC_BITS),
      .CXW          (CXW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_action      (req_action),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .req_row         (req_row),
      .map_height      (map_height_ff),
      .q_status        (q_status),
      .push            (push),
      .push_end        (push_end),
      .push_value      (push_value),
      .busy            (front_busy)
   );

   psf_queue #(.W(CXW + 1)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_end, push_value}),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   psf_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .CXW          (CXW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_end       (head_data[CXW]),
      .head_value     ($signed(head_data[CXW-1:0])),
      .map_width      (map_width_ff),
      .pop            (pop),
      .busy           (back_busy),
      .rsp_valid      (rsp_valid),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_span_valid (rsp_span_valid),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== design/psf_checker.sv =====
// ----------------------------------------------------------------------------
// psf_checker
// Port-level checks on the span fill results and on busy after a query, bound to the top level.
// ----------------------------------------------------------------------------
module psf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_action,
   input logic                   rsp_valid,
   input logic [psf_pkg::MW-1:0] rsp_span_start,
   input logic [psf_pkg::MW-1:0] rsp_span_end,
   input logic                   rsp_span_valid,
   input logic                   rsp_last
);

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |-> rsp_last)
      else $error("empty result without last");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |-> rsp_span_start == '0 && rsp_span_end == '0)
      else $error("empty result carries columns");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_valid |-> rsp_span_start <= rsp_span_end)
      else $error("span start beyond end");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == psf_pkg::ACT_QUERY |=> busy)
      else $error("query request did not raise busy");

endmodule

bind polygon_scanline_span_fill psf_checker u_psf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_span_start (rsp_span_start),
   .rsp_span_end   (rsp_span_end),
   .rsp_span_valid (rsp_span_valid),
   .rsp_last       (rsp_last)
);

// ===== tb/sv/polygon_scanline_span_fill_tb.sv =====
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill_tb
// Drives vertex loads and row queries into the span fill block, predicts the
// even-odd spans of every query, and checks each result as it leaves the
// block. The map size is rewritten between phases through the APB port.
// ----------------------------------------------------------------------------
module polygon_scanline_span_fill_tb;

   localparam int NVERT     = psf_pkg::MAX_VERTICES_DEF;
   localparam int XW        = psf_pkg::XW;
   localparam int RW        = psf_pkg::RW;
   localparam int MW        = psf_pkg::MW;
   localparam int STALL_MAX = 20000;

   typedef struct {
      logic          action;
      logic [XW-1:0] vx;
      logic [XW-1:0] vy;
      logic          lastv;
      logic [RW-1:0] row;
      bit            drain;
   } request_type;

   typedef struct {
      logic [MW-1:0] s;
      logic [MW-1:0] e;
      logic          v;
      logic          l;
   } span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = psf_pkg::ACT_LOAD;
   logic [XW-1:0] req_vertex_x = '0;
   logic [XW-1:0] req_vertex_y = '0;
   logic req_last_vertex = 1'b0;
   logic [RW-1:0] req_row = '0;
   logic rsp_valid;
   logic [MW-1:0] rsp_span_start;
   logic [MW-1:0] rsp_span_end;
   logic rsp_span_valid;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [psf_pkg::CSR_AW-1:0] paddr = '0;
   logic [psf_pkg::CSR_DW-1:0] pwdata = '0;
   logic [psf_pkg::CSR_DW-1:0] prdata;
   logic pready;

   request_type pending[$];
   span_type    spans_due[$];

   logic [XW-1:0] poly_x[NVERT];
   logic [XW-1:0] poly_y[NVERT];
   int            poly_n = 0;
   bit            poly_closed = 0;
   logic [MW-1:0] map_w = psf_pkg::MAP_WIDTH_RST;
   logic [MW-1:0] map_h = psf_pkg::MAP_HEIGHT_RST;

   bit quiet = 0;
   int errors = 0;
   int n_queries = 0;
   int n_spans = 0;
   int n_loads = 0;
   int stall = 0;

   polygon_scanline_span_fill uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y), .req_last_vertex(req_last_vertex),
      .req_row(req_row), .rsp_valid(rsp_valid), .rsp_span_start(rsp_span_start),
      .rsp_span_end(rsp_span_end), .rsp_span_valid(rsp_span_valid),
      .rsp_last(rsp_last), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic longint half_shifted(logic [XW-1:0] raw);
      return 2 * longint'($signed(raw)) - (longint'(1) << psf_pkg::FRAC_BITS_DEF);
   endfunction

   function automatic longint ceil_quot(longint t, longint d);
      longint q;
      q = t / d;
      if ((t % d) != 0 && t > 0) q = q + 1;
      return q;
   endfunction

   task automatic predict_spans(logic [RW-1:0] row);
      int xing[NVERT];
      int nc, cnt, j, k, v;
      longint sc, yrow, wmax, x0, y0, x1, y1, xl, yl, yh, dx, dy, a, b, s, e;
      span_type sp;
      nc = 0;
      cnt = 0;
      sc = longint'(1) << (psf_pkg::FRAC_BITS_DEF + 1);
      if (poly_closed && poly_n >= 3 && row < map_h) begin
         yrow = longint'(row) * sc;
         wmax = longint'(map_w) - 1;
         for (int i = 0; i < poly_n; i++) begin
            j = (i + 1 == poly_n) ? 0 : i + 1;
            x0 = half_shifted(poly_x[i]);
            y0 = half_shifted(poly_y[i]);
            x1 = half_shifted(poly_x[j]);
            y1 = half_shifted(poly_y[j]);
            if (y0 == y1) continue;
            if (y0 < y1) begin
               xl = x0; yl = y0; yh = y1; dx = x1 - x0;
            end else begin
               xl = x1; yl = y1; yh = y0; dx = x0 - x1;
            end
            dy = yh - yl;
            if (yrow <= yl || yrow > yh) continue;
            xing[nc] = int'(ceil_quot(xl * dy + (yrow - yl) * dx, dy * sc));
            nc++;
         end
         for (int i = 1; i < nc; i++) begin
            v = xing[i];
            k = i;
            while (k > 0 && xing[k-1] > v) begin
               xing[k] = xing[k-1];
               k--;
            end
            xing[k] = v;
         end
         for (int i = 0; i + 1 < nc && cnt < psf_pkg::MAX_RESULTS; i += 2) begin
            a = xing[i];
            b = longint'(xing[i+1]) - 1;
            if (b < 0 || a > wmax) continue;
            s = (a < 0) ? 0 : a;
            e = (b > wmax) ? wmax : b;
            if (s > e) continue;
            sp.s = MW'(s); sp.e = MW'(e); sp.v = 1'b1; sp.l = 1'b0;
            spans_due.insert(spans_due.size(), sp);
            cnt++;
         end
      end
      if (cnt == 0) begin
         sp.s = '0; sp.e = '0; sp.v = 1'b0; sp.l = 1'b1;
         spans_due.insert(spans_due.size(), sp);
      end else begin
         spans_due[spans_due.size()-1].l = 1'b1;
         n_spans += cnt;
      end
   endtask

   task automatic apply_request();
      if (req_action == psf_pkg::ACT_LOAD) begin
         n_loads++;
         if (poly_closed) begin
            poly_n = 0;
            poly_closed = 0;
         end
         if (poly_n < NVERT) begin
            poly_x[poly_n] = req_vertex_x;
            poly_y[poly_n] = req_vertex_y;
            poly_n++;
         end
         if (req_last_vertex) poly_closed = 1;
      end else begin
         n_queries++;
         predict_spans(req_row);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) apply_request();
         if (!start || !busy) begin
            if (pending.size() > 0 && (quiet || $urandom_range(99) >= 25) &&
                (!pending[0].drain || (!start && !busy && spans_due.size() == 0))) begin
               req_action      <= pending[0].action;
               req_vertex_x    <= pending[0].vx;
               req_vertex_y    <= pending[0].vy;
               req_last_vertex <= pending[0].lastv;
               req_row         <= pending[0].row;
               start           <= 1'b1;
               void'(pending.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (spans_due.size() == 0) begin
            $display("%0t: unexpected span %h..%h valid %b last %b", $time,
                     rsp_span_start, rsp_span_end, rsp_span_valid, rsp_last);
            errors++;
         end else begin
            if (rsp_span_start !== spans_due[0].s) begin
               $display("%0t: span_start expected %h actual %h", $time,
                        spans_due[0].s, rsp_span_start);
               errors++;
            end
            if (rsp_span_end !== spans_due[0].e) begin
               $display("%0t: span_end expected %h actual %h", $time,
                        spans_due[0].e, rsp_span_end);
               errors++;
            end
            if (rsp_span_valid !== spans_due[0].v) begin
               $display("%0t: span_valid expected %b actual %b", $time,
                        spans_due[0].v, rsp_span_valid);
               errors++;
            end
            if (rsp_last !== spans_due[0].l) begin
               $display("%0t: last expected %b actual %b", $time,
                        spans_due[0].l, rsp_last);
               errors++;
            end
            void'(spans_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || psel) stall <= 0;
         else stall <= stall + 1;
         if (stall == STALL_MAX) begin
            $display("%0t: no progress, %0d spans outstanding", $time, spans_due.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic add_req(logic act, logic [XW-1:0] x, logic [XW-1:0] y, logic lv,
                          logic [RW-1:0] row, bit drain = 0);
      request_type r;
      r.action = act; r.vx = x; r.vy = y; r.lastv = lv; r.row = row; r.drain = drain;
      pending.insert(pending.size(), r);
   endtask

   function automatic logic [XW-1:0] cells(int c, int frac = 0);
      return XW'(c * 256 + frac);
   endfunction

   task automatic add_vertex(int cx, int cy, logic lv);
      add_req(psf_pkg::ACT_LOAD, cells(cx, $urandom_range(255)),
              cells(cy, $urandom_range(255)), lv, '0);
   endtask

   task automatic add_query(int row);
      add_req(psf_pkg::ACT_QUERY, XW'($urandom), XW'($urandom), $urandom_range(1),
              RW'(row));
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending.size() != 0 || start || spans_due.size() != 0 || busy);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [MW-1:0] val);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == psf_pkg::REG_MAP_WIDTH) map_w = val;
      else map_h = val;
   endtask

   task automatic random_part(int count, int xspan, int yspan);
      int added, r, nv, nq;
      added = 0;
      while (added < count) begin
         r = $urandom_range(99);
         if (r < 10) begin
            add_req($urandom_range(1), XW'($urandom), XW'($urandom), $urandom_range(1),
                    RW'($urandom));
            added++;
         end else begin
            if (r < 15) nv = $urandom_range(NVERT + 8, NVERT - 2);
            else if (r < 20) nv = $urandom_range(2, 1);
            else nv = $urandom_range(10, 3);
            for (int i = 0; i < nv; i++) begin
               if (r >= 20 && r < 25 && i == nv - 1) add_query($urandom_range(yspan));
               add_vertex(int'($urandom_range(xspan)) - xspan / 8,
                          int'($urandom_range(yspan)) - yspan / 8, i == nv - 1);
            end
            nq = $urandom_range(4, 1);
            for (int i = 0; i < nq; i++) add_query($urandom_range(yspan + 4));
            added += nv + nq;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      add_query(5);
      add_vertex(0, 0, 1'b0);
      add_vertex(10, 10, 1'b1);
      add_query(5);
      add_req(psf_pkg::ACT_LOAD, cells(2), cells(2), 1'b0, '0);
      add_req(psf_pkg::ACT_LOAD, cells(20), cells(2), 1'b0, '0);
      add_req(psf_pkg::ACT_LOAD, cells(20), cells(12), 1'b0, '0);
      add_req(psf_pkg::ACT_LOAD, cells(2), cells(12), 1'b1, '0);
      add_query(2);
      add_query(7);
      add_query(12);
      add_query(1024);
      add_query(65535);
      add_req(psf_pkg::ACT_LOAD, 24'h800000, 24'h800000, 1'b0, '0);
      add_req(psf_pkg::ACT_LOAD, 24'h7fffff, 24'h800000, 1'b0, '0);
      add_req(psf_pkg::ACT_LOAD, 24'h7fffff, 24'h7fffff, 1'b0, '0);
      add_req(psf_pkg::ACT_LOAD, 24'h800000, 24'h7fffff, 1'b1, '0);
      add_query(0);
      add_query(1023);
      add_vertex(1, 1, 1'b0);
      add_query(1);
      for (int k = 0; k < NVERT / 2 + 1; k++) begin
         add_req(psf_pkg::ACT_LOAD, cells(6 * k), cells(0), 1'b0, '0, k == 0);
         add_req(psf_pkg::ACT_LOAD, cells(6 * k + 3), cells(20), k == NVERT / 2, '0);
      end
      add_query(10);
      wait_idle();

      csr_write(psf_pkg::REG_MAP_WIDTH, 16'd40);
      csr_write(psf_pkg::REG_MAP_HEIGHT, 16'd64);
      random_part(110, 60, 70);
      wait_idle();

      csr_write(psf_pkg::REG_MAP_WIDTH, 16'hffff);
      csr_write(psf_pkg::REG_MAP_HEIGHT, 16'hffff);
      quiet = 1;
      random_part(60, 400, 400);
      wait_idle();
      quiet = 0;
      random_part(40, 30000, 30000);
      wait_idle();

      csr_write(psf_pkg::REG_MAP_WIDTH, 16'd1);
      csr_write(psf_pkg::REG_MAP_HEIGHT, 16'd1);
      random_part(25, 6, 3);
      wait_idle();

      csr_write(psf_pkg::REG_MAP_WIDTH, 16'd0);
      csr_write(psf_pkg::REG_MAP_HEIGHT, 16'd200);
      random_part(20, 60, 60);
      wait_idle();
      csr_write(psf_pkg::REG_MAP_WIDTH, 16'd300);
      csr_write(psf_pkg::REG_MAP_HEIGHT, 16'd0);
      random_part(12, 60, 60);

      wait_idle();
      repeat (900) @(posedge clock);
      if (spans_due.size() != 0) begin
         $display("%0t: %0d expected spans never arrived", $time, spans_due.size());
         errors++;
      end
      $display("Loaded %0d vertices, ran %0d row queries yielding %0d spans,", n_loads,
               n_queries, n_spans);
      $display("over map sizes from 0 to 65535 with %0d mismatches.", errors);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
